// ===== hdl/cane2e_pkg.sv =====
// Shared types, codes and the CRC-8 byte step for the CAN end-to-end protection table.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cane2e_pkg;

    localparam int unsigned ID_W        = 29;
    localparam int unsigned FRAME_BYTES = 8;
    localparam int unsigned DATA_W      = 8 * FRAME_BYTES;
    localparam int unsigned NBYTES_W    = 4;

    localparam logic [7:0] CRC_INIT = 8'hEC;
    localparam logic [7:0] CRC_POLY = 8'hE5;

    localparam logic [1:0] PROTO_OTHER  = 2'd0;
    localparam logic [1:0] PROTO_ECES   = 2'd1;
    localparam logic [1:0] PROTO_SAFETY = 2'd2;

    typedef enum logic [2:0] {
        MODE_SET      = 3'd0,
        MODE_NEXT     = 3'd1,
        MODE_CLR_CNT  = 3'd2,
        MODE_CLR_ALL  = 3'd3,
        MODE_CLR_CNTS = 3'd4,
        MODE_CRC      = 3'd5,
        MODE_INV      = 3'd6,
        MODE_NOP      = 3'd7
    } t_mode;

    // One table slot as held in the memory word.
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic              enable;
        logic [1:0]        protocol;
        logic              count_valid;
        logic [7:0]        count;
    } t_entry;

    // Request from the sequencer to the CRC unit.
    typedef struct packed {
        logic                start;
        logic [DATA_W-1:0]   data;
        logic [NBYTES_W-1:0] nbytes;
    } t_crc_req;

    // Folds one byte into the CRC, most significant bit first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cane2e_mem.sv =====
// Single-port-write, single-port-read table memory with a registered read.
// Holds one cane2e_pkg::t_entry per slot; depends on cane2e_pkg.
`default_nettype none

module cane2e_mem #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire cane2e_pkg::t_entry i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [AW-1:0]     i_rd_addr,
    output cane2e_pkg::t_entry     o_rd_data
);

    cane2e_pkg::t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cane2e_crc.sv =====
// Byte-serial CRC-8 unit: one data byte per cycle, up to eight bytes.
// Depends on cane2e_pkg for the request type and the byte step.
`default_nettype none

module cane2e_crc (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire cane2e_pkg::t_crc_req i_req,
    output logic [7:0]                o_crc,
    output logic                      o_done
);

    logic [7:0]                          r_crc;
    logic [cane2e_pkg::DATA_W-1:0]       r_data;
    logic [cane2e_pkg::NBYTES_W-1:0]     r_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_req.start) begin
            r_crc  <= cane2e_pkg::CRC_INIT;
            r_data <= i_req.data;
            // Byte counts beyond the frame length saturate.
            if (i_req.nbytes > cane2e_pkg::NBYTES_W'(cane2e_pkg::FRAME_BYTES)) begin
                r_left <= cane2e_pkg::NBYTES_W'(cane2e_pkg::FRAME_BYTES);
            end else begin
                r_left <= i_req.nbytes;
            end
        end else if (r_left != '0) begin
            r_crc  <= cane2e_pkg::crc8_byte(r_crc, r_data[7:0]);
            r_data <= r_data >> 8;
            r_left <= r_left - 1'b1;
        end
    end

    assign o_crc  = r_crc;
    assign o_done = (r_left == '0);

endmodule

`default_nettype wire

// ===== hdl/can_e2e_counter_crc_table.sv =====
// Each transfer runs a table sweep (S_SCAN) that reads one memory slot per cycle, then S_DRAIN
// and S_ACT, where a CRC request also waits for the byte-serial CRC unit; mode 7 skips the sweep.
// No new transfer is taken before the last result shows; a new transfer is taken in the cycle the
// result shows. The receiver cannot stall; o_valid is high for exactly one cycle per item.
// Reset (synchronous, active low) starts a clearing pass over every table slot with busy high.
// Depends on cane2e_pkg, cane2e_mem and cane2e_crc.
`default_nettype none

module can_e2e_counter_crc_table #(
    parameter int unsigned TABLE_ENTRIES = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [2:0]                    i_mode,
    input  wire logic [cane2e_pkg::ID_W-1:0]   i_message_id,
    input  wire logic                          i_enable,
    input  wire logic [1:0]                    i_protocol,
    input  wire logic [7:0]                    i_counter_in,
    input  wire logic [cane2e_pkg::DATA_W-1:0] i_data,
    input  wire logic [3:0]                    i_byte_count,
    output logic                               o_valid,
    output logic [7:0]                         o_value,
    output logic [cane2e_pkg::DATA_W-1:0]      o_inverted,
    output logic                               o_invert_supported,
    output logic                               o_table_full
);

    localparam int unsigned AW   = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_ACT
    } t_state;

    t_state                         r_state;
    logic [AW-1:0]                  r_addr;
    logic                           r_pend;
    logic [AW-1:0]                  r_pend_addr;
    cane2e_pkg::t_mode              r_mode;
    logic [cane2e_pkg::ID_W-1:0]    r_id;
    logic                           r_en;
    logic [1:0]                     r_proto;
    logic [7:0]                     r_cnt_in;
    logic [cane2e_pkg::DATA_W-1:0]  r_data;
    logic                           r_found;
    logic [AW-1:0]                  r_slot;
    cane2e_pkg::t_entry             r_hit;
    logic                           r_free_ok;
    logic [AW-1:0]                  r_free;

    logic                           mem_wr_en;
    logic [AW-1:0]                  mem_wr_addr;
    cane2e_pkg::t_entry             mem_wr_data;
    logic                           mem_rd_en;
    cane2e_pkg::t_entry             mem_rd_data;

    cane2e_pkg::t_crc_req           crc_req;
    logic [7:0]                     crc_val;
    logic                           crc_done;

    logic                           accept;
    logic                           eces;
    logic                           act_go;
    logic [7:0]                     n_count;
    logic [7:0]                     n_value;
    logic [cane2e_pkg::DATA_W-1:0]  n_inverted;
    logic                           n_sup;
    logic                           n_full;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && (r_state == S_IDLE);

    assign crc_req.start  = accept;
    assign crc_req.data   = i_data;
    assign crc_req.nbytes = i_byte_count;

    cane2e_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (mem_rd_data)
    );

    cane2e_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (crc_req),
        .o_crc   (crc_val),
        .o_done  (crc_done)
    );

    assign eces    = r_found && r_hit.enable && (r_hit.protocol == cane2e_pkg::PROTO_ECES);
    assign n_count = r_hit.count_valid ? (r_hit.count + 8'd1) : 8'd0;
    // Only a CRC request has to wait for the byte-serial unit.
    assign act_go  = !((r_mode == cane2e_pkg::MODE_CRC) && !crc_done);
    assign mem_rd_en = (r_state == S_SCAN);

    always_comb begin
        n_value    = '0;
        n_inverted = '0;
        n_sup      = 1'b0;
        n_full     = 1'b0;
        case (r_mode)
            cane2e_pkg::MODE_SET: begin
                n_full = !r_found && !r_free_ok;
            end
            cane2e_pkg::MODE_NEXT: begin
                n_value = eces ? n_count : r_cnt_in;
            end
            cane2e_pkg::MODE_CRC: begin
                n_value = eces ? crc_val : r_data[cane2e_pkg::DATA_W-1 -: 8];
            end
            cane2e_pkg::MODE_INV: begin
                n_inverted = ~r_data;
                n_sup = r_found && r_hit.enable &&
                        (r_hit.protocol == cane2e_pkg::PROTO_SAFETY);
            end
            default: begin
                n_value = '0;
            end
        endcase
    end

    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_addr;
        mem_wr_data = '0;
        case (r_state)
            S_CLEAR: begin
                mem_wr_en = 1'b1;
            end
            S_SCAN, S_DRAIN: begin
                // Whole-table clears rewrite each slot as its read data returns.
                mem_wr_addr = r_pend_addr;
                if (r_pend && (r_mode == cane2e_pkg::MODE_CLR_ALL)) begin
                    mem_wr_en = 1'b1;
                end else if (r_pend && (r_mode == cane2e_pkg::MODE_CLR_CNTS)) begin
                    mem_wr_en               = 1'b1;
                    mem_wr_data             = mem_rd_data;
                    mem_wr_data.count_valid = 1'b0;
                end
            end
            S_ACT: begin
                mem_wr_addr = r_slot;
                mem_wr_data = r_hit;
                case (r_mode)
                    cane2e_pkg::MODE_SET: begin
                        if (r_found) begin
                            mem_wr_en            = 1'b1;
                            mem_wr_data.enable   = r_en;
                            mem_wr_data.protocol = r_proto;
                        end else if (r_free_ok) begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = r_free;
                            mem_wr_data = '{valid: 1'b1, id: r_id, enable: r_en,
                                            protocol: r_proto, count_valid: 1'b0,
                                            count: 8'd0};
                        end
                    end
                    cane2e_pkg::MODE_NEXT: begin
                        if (eces) begin
                            mem_wr_en               = 1'b1;
                            mem_wr_data.count_valid = 1'b1;
                            mem_wr_data.count       = n_count;
                        end
                    end
                    cane2e_pkg::MODE_CLR_CNT: begin
                        if (r_found && r_en && (r_proto == cane2e_pkg::PROTO_ECES)) begin
                            mem_wr_en               = 1'b1;
                            mem_wr_data.count_valid = 1'b0;
                        end
                    end
                    default: begin
                        mem_wr_en = 1'b0;
                    end
                endcase
            end
            default: begin
                mem_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            o_valid <= (r_state == S_ACT) && act_go;

            // Search bookkeeping for each word returned by the sweep.
            if (r_pend) begin
                if (mem_rd_data.valid && (mem_rd_data.id == r_id) && !r_found) begin
                    r_found <= 1'b1;
                    r_slot  <= r_pend_addr;
                    r_hit   <= mem_rd_data;
                end
                if (!mem_rd_data.valid && !r_free_ok) begin
                    r_free_ok <= 1'b1;
                    r_free    <= r_pend_addr;
                end
            end

            case (r_state)
                S_CLEAR: begin
                    if (r_addr == LAST) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_mode    <= cane2e_pkg::t_mode'(i_mode);
                        r_id      <= i_message_id;
                        r_en      <= i_enable;
                        r_proto   <= i_protocol;
                        r_cnt_in  <= i_counter_in;
                        r_data    <= i_data;
                        r_found   <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_addr    <= '0;
                        if (cane2e_pkg::t_mode'(i_mode) == cane2e_pkg::MODE_NOP) begin
                            r_state <= S_ACT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_pend      <= 1'b1;
                    r_pend_addr <= r_addr;
                    if (r_addr == LAST) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_pend  <= 1'b0;
                    r_state <= S_ACT;
                end
                S_ACT: begin
                    if (act_go) begin
                        o_value            <= n_value;
                        o_inverted         <= n_inverted;
                        o_invert_supported <= n_sup;
                        o_table_full       <= n_full;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cane2e_chk.sv =====
// Port-level checker for can_e2e_counter_crc_table, attached by the bind below.
// Sees only the top level's ports; depends on cane2e_pkg for widths.
`default_nettype none

module cane2e_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          o_valid,
    input wire logic [7:0]                    o_value,
    input wire logic [cane2e_pkg::DATA_W-1:0] o_inverted,
    input wire logic                          o_invert_supported,
    input wire logic                          o_table_full
);

    // Every transfer taken while idle makes the block busy afterwards.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer taken but block not busy afterwards");

    // The strobe marks the return to idle and lasts one cycle.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while still busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // A full-table report belongs to a set request, which carries no other result.
    a_full_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |->
            (o_value == 8'd0) && (o_inverted == '0) && !o_invert_supported)
        else $error("table full reported together with other result fields");

endmodule

bind can_e2e_counter_crc_table cane2e_chk u_cane2e_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_valid            (o_valid),
    .o_value            (o_value),
    .o_inverted         (o_inverted),
    .o_invert_supported (o_invert_supported),
    .o_table_full       (o_table_full)
);

`default_nettype wire
